@@ src/calendar_date_arithmetic_core_macros.svh @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic assertion macros
// Clocked assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CDA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`define CDA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CDA_ASSERT_IMPL(lbl, pre, post, msg)
`define CDA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ src/cda_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Item layouts, calendar constants and month tables.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned MaxYear     = 9999;
  localparam int          InWidth     = 72;
  localparam int          OutWidth    = 56;
  localparam int          AccWidth    = 26;
  localparam int          SerialWidth = 23;
  localparam int          YearWidth   = 17;
  localparam int          QuotWidth   = 9;
  localparam int          RecipShift  = 19;
  localparam int          BlockDays   = 146097;
  localparam int          BlockYears  = 400;
  localparam int          DiffMax     = 4194303;
  localparam int          DiffMin     = -4194304;
  // first day past the last representable year, as a day number
  localparam int LimitDays = 365 * (MaxYear + 1) + (MaxYear + 4) / 4
                             - (MaxYear + 100) / 100 + (MaxYear + 400) / 400;
  // floor(x / 100) == (x * Recip100) >> RecipShift for x below 16500
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam logic [12:0] DaysYear = 13'd365;

  typedef logic signed [AccWidth-1:0] acc_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [20:0] day_offset;
    logic [4:0]         second_day;
    logic [3:0]         second_month;
    logic [13:0]        second_year;
    logic [4:0]         first_day;
    logic [3:0]         first_month;
    logic [13:0]        first_year;
  } cda_in_t;

  typedef struct packed {
    logic [4:0]         pad;
    logic               out_of_range;
    logic               second_valid;
    logic               first_valid;
    logic               dates_equal;
    logic               first_greater;
    logic signed [22:0] day_difference;
    logic [4:0]         shifted_day;
    logic [3:0]         shifted_month;
    logic [13:0]        shifted_year;
  } cda_out_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before_month(logic [3:0] m);
    logic [8:0] days;
    unique case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

@@ src/calendar_date_arithmetic_core.sv @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic core
// Shifts a Gregorian date by a day offset and compares it with a second date.
// ----------------------------------------------------------------------------
// Usage: the slave stream takes one item holding two dates and a signed day
// offset; the master stream returns one item per input: the shifted date,
// the signed day difference, compare flags, validity flags and a clamp flag.
// The first and then the second date is turned into a day number on one
// shared adder and a small shared multiplier (reciprocal division by 100).
// The difference and then the shifted day number are formed on the same
// adder. The shifted date is then walked back out: 400-year blocks, single
// years of 365 or 366 days, then months. An invalid first date or a clamped
// date skips the walk. s_axis_tready is high only while the core is
// idle; a finished result waits in the output register, so the next item can
// be taken while the receiver stalls. The core holds its last result until it
// is taken. Reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
`include "calendar_date_arithmetic_core_macros.svh"

module calendar_date_arithmetic_core import cda_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // first_year, first_month, first_day, second_year, second_month,
  // second_day, day_offset, zero pad
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // shifted_year, shifted_month, shifted_day, day_difference, first_greater,
  // dates_equal, first_valid, second_valid, out_of_range, zero pad
  output logic [OutWidth-1:0] m_axis_tdata
);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StSerial = 8'b0000_0010,
    StDiff   = 8'b0000_0100,
    StOffs   = 8'b0000_1000,
    StBlock  = 8'b0001_0000,
    StYear   = 8'b0010_0000,
    StMonth  = 8'b0100_0000,
    StFin    = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    SpMul365   = 3'd0,
    SpQuarter  = 3'd1,
    SpCeil100  = 3'd2,
    SpFloor100 = 3'd3,
    SpCeil400  = 3'd4,
    SpFloor400 = 3'd5,
    SpMonth    = 3'd6
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   sel_q, sel_d;
  logic   out_valid_q, out_valid_d;

  cda_in_t                in_q;
  cda_out_t               out_q, out_d;
  acc_t                   acc_q, acc_d;
  logic [QuotWidth-1:0]   ceil_q, ceil_d;
  logic                   div100_q, div100_d;
  logic                   div400_q, div400_d;
  logic [SerialWidth-1:0] s1_q, s1_d, s2_q, s2_d;
  logic                   v1_q, v1_d, v2_q, v2_d;
  logic [22:0]            diff_q, diff_d;
  logic [YearWidth-1:0]   yr_q, yr_d;
  logic [8:0]             j_q, j_d;
  logic [6:0]             c100_q, c100_d;
  logic [3:0]             mo_q, mo_d;
  logic                   oor_q, oor_d;

  logic [13:0]          cur_y;
  logic [3:0]           cur_m;
  logic [4:0]           cur_d;
  logic [12:0]          y_quarter;
  logic                 leap_cur;
  logic                 leap_j;
  logic                 cur_valid;
  logic [14:0]          mul_a;
  logic [12:0]          mul_b;
  logic [27:0]          prod;
  logic [QuotWidth-1:0] quot;
  acc_t                 add_a, add_b, sum;
  logic                 accept, out_load;
  logic                 gt, eq;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StFin) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign cur_y     = sel_q ? in_q.second_year  : in_q.first_year;
  assign cur_m     = sel_q ? in_q.second_month : in_q.first_month;
  assign cur_d     = sel_q ? in_q.second_day   : in_q.first_day;
  // ceil(y / 4)
  assign y_quarter = 13'(({1'b0, cur_y} + 15'd3) >> 2);
  assign leap_cur  = (cur_y[1:0] == 2'd0) && (!div100_q || div400_q);
  assign cur_valid = (cur_d != 5'd0) && (cur_d <= month_days(cur_m, leap_cur));
  // year within the 400-year block: leap unless a century other than block start
  assign leap_j    = (j_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (j_q == 9'd0));

  assign prod = 28'(mul_a) * 28'(mul_b);
  assign quot = prod[RecipShift +: QuotWidth];
  assign sum  = add_a + add_b;

  assign gt = (in_q.first_year > in_q.second_year)
           || ((in_q.first_year == in_q.second_year) && (in_q.first_month > in_q.second_month))
           || ((in_q.first_year == in_q.second_year) && (in_q.first_month == in_q.second_month)
               && (in_q.first_day > in_q.second_day));
  assign eq = (in_q.first_year == in_q.second_year) && (in_q.first_month == in_q.second_month)
           && (in_q.first_day == in_q.second_day);

  // operand selection for the shared multiplier and adder
  always_comb begin
    mul_a = 15'd0;
    mul_b = Recip100;
    add_a = acc_q;
    add_b = '0;
    unique case (state_q)
      StSerial: begin
        unique case (step_q)
          SpMul365: begin
            mul_a = {1'b0, cur_y};
            mul_b = DaysYear;
            add_a = '0;
            add_b = acc_t'({{(AccWidth-SerialWidth){1'b0}}, prod[SerialWidth-1:0]});
          end
          SpQuarter: add_b = acc_t'({{(AccWidth-13){1'b0}}, y_quarter});
          SpCeil100: begin
            mul_a = {1'b0, cur_y} + 15'd99;
            add_b = -acc_t'({{(AccWidth-QuotWidth){1'b0}}, quot});
          end
          SpFloor100: mul_a = {1'b0, cur_y};
          SpCeil400: begin
            mul_a = {2'b0, y_quarter} + 15'd99;
            add_b = acc_t'({{(AccWidth-QuotWidth){1'b0}}, quot});
          end
          SpFloor400: mul_a = {3'b0, cur_y[13:2]};
          SpMonth: begin
            add_b = acc_t'({{(AccWidth-9){1'b0}}, days_before_month(cur_m)})
                  + acc_t'({{(AccWidth-1){1'b0}}, leap_cur && (cur_m > 4'd2)})
                  + acc_t'({{(AccWidth-5){1'b0}}, cur_d}) - acc_t'(1);
          end
          default: add_b = '0;
        endcase
      end
      StDiff: begin
        add_a = acc_t'({{(AccWidth-SerialWidth){1'b0}}, s1_q});
        add_b = -acc_t'({{(AccWidth-SerialWidth){1'b0}}, s2_q});
      end
      StOffs: begin
        add_a = acc_t'({{(AccWidth-SerialWidth){1'b0}}, s1_q});
        add_b = acc_t'({{(AccWidth-21){in_q.day_offset[20]}}, in_q.day_offset});
      end
      StBlock: add_b = -acc_t'(BlockDays);
      StYear:  add_b = leap_j ? -acc_t'(366) : -acc_t'(365);
      StMonth: add_b = -acc_t'({{(AccWidth-5){1'b0}}, month_days(mo_q, leap_j)});
      default: add_b = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    acc_d       = acc_q;
    ceil_d      = ceil_q;
    div100_d    = div100_q;
    div400_d    = div400_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    diff_d      = diff_q;
    yr_d        = yr_q;
    j_d         = j_q;
    c100_d      = c100_q;
    mo_d        = mo_q;
    oor_d       = oor_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSerial;
          step_d  = SpMul365;
          sel_d   = 1'b0;
        end
      end
      StSerial: begin
        acc_d  = sum;
        step_d = step_e'(step_q + 3'd1);
        unique case (step_q)
          SpCeil100:  ceil_d = quot;
          SpFloor100: div100_d = (quot == ceil_q);
          SpCeil400:  ceil_d = quot;
          SpFloor400: div400_d = (quot == ceil_q);
          SpMonth: begin
            step_d = SpMul365;
            if (!sel_q) begin
              s1_d  = sum[SerialWidth-1:0];
              v1_d  = cur_valid;
              sel_d = 1'b1;
            end else begin
              s2_d    = sum[SerialWidth-1:0];
              v2_d    = cur_valid;
              state_d = StDiff;
            end
          end
          default: ;
        endcase
      end
      StDiff: begin
        if (!(v1_q && v2_q)) begin
          diff_d = 23'd0;
        end else if (sum > acc_t'(DiffMax)) begin
          diff_d = 23'(DiffMax);
        end else if (sum < acc_t'(DiffMin)) begin
          diff_d = 23'(DiffMin);
        end else begin
          diff_d = sum[22:0];
        end
        state_d = StOffs;
      end
      StOffs: begin
        acc_d  = sum;
        yr_d   = '0;
        j_d    = 9'd0;
        c100_d = 7'd0;
        mo_d   = 4'd1;
        oor_d  = 1'b0;
        state_d = StBlock;
        if (!v1_q) begin
          // invalid first date: day field of acc + 1 wraps to zero
          mo_d    = 4'd0;
          acc_d   = -acc_t'(1);
          state_d = StFin;
        end else if (sum[AccWidth-1]) begin
          acc_d   = '0;
          oor_d   = 1'b1;
          state_d = StFin;
        end else if (sum >= acc_t'(LimitDays)) begin
          yr_d    = YearWidth'(MaxYear);
          mo_d    = 4'd12;
          acc_d   = acc_t'(30);
          oor_d   = 1'b1;
          state_d = StFin;
        end
      end
      StBlock: begin
        if (!sum[AccWidth-1]) begin
          acc_d = sum;
          yr_d  = yr_q + YearWidth'(BlockYears);
        end else begin
          state_d = StYear;
        end
      end
      StYear: begin
        if (!sum[AccWidth-1]) begin
          acc_d  = sum;
          yr_d   = yr_q + YearWidth'(1);
          j_d    = j_q + 9'd1;
          c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
        end else begin
          state_d = StMonth;
        end
      end
      StMonth: begin
        if ((mo_q < 4'd12) && !sum[AccWidth-1]) begin
          acc_d = sum;
          mo_d  = mo_q + 4'd1;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          out_d.pad            = 5'd0;
          out_d.shifted_year   = yr_q[13:0];
          out_d.shifted_month  = mo_q;
          out_d.shifted_day    = acc_q[4:0] + 5'd1;
          out_d.day_difference = diff_q;
          out_d.first_greater  = v1_q && gt;
          out_d.dates_equal    = v1_q && eq;
          out_d.first_valid    = v1_q;
          out_d.second_valid   = v2_q;
          out_d.out_of_range   = oor_q;
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= SpMul365;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= cda_in_t'(s_axis_tdata);
    end
    out_q    <= out_d;
    acc_q    <= acc_d;
    ceil_q   <= ceil_d;
    div100_q <= div100_d;
    div400_q <= div400_d;
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    v1_q     <= v1_d;
    v2_q     <= v2_d;
    diff_q   <= diff_d;
    yr_q     <= yr_d;
    j_q      <= j_d;
    c100_q   <= c100_d;
    mo_q     <= mo_d;
    oor_q    <= oor_d;
  end

  `CDA_ASSERT_NEXT(a_accept_starts, accept,
    (state_q == StSerial) && (step_q == SpMul365) && !sel_q,
    "accepted item did not start the serial sequence")
  `CDA_ASSERT_IMPL(a_invalid_zero, m_axis_tvalid && !out_q.first_valid,
    (out_q.shifted_year == 14'd0) && (out_q.shifted_month == 4'd0)
      && (out_q.shifted_day == 5'd0) && (out_q.day_difference == 23'd0)
      && !out_q.out_of_range,
    "invalid first date gave nonzero result")
  `CDA_ASSERT_IMPL(a_clamp_value, m_axis_tvalid && out_q.out_of_range,
    ((out_q.shifted_year == 14'd0) && (out_q.shifted_month == 4'd1)
      && (out_q.shifted_day == 5'd1))
      || ((out_q.shifted_year == 14'(MaxYear)) && (out_q.shifted_month == 4'd12)
      && (out_q.shifted_day == 5'd31)),
    "clamped date is not a range limit")
  `CDA_ASSERT_IMPL(a_year_walk, state_q == StYear,
    (j_q < 9'd400) && !acc_q[AccWidth-1],
    "year walk left its 400-year block")
  `CDA_ASSERT_IMPL(a_month_walk, state_q == StMonth,
    (mo_q >= 4'd1) && (mo_q <= 4'd12) && !acc_q[AccWidth-1] && (acc_q < acc_t'(366)),
    "month walk out of range")

endmodule

@@ test/cda_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic result checker
// Watches both streams of the core. It predicts the result of every accepted
// item and compares each returned item with the oldest prediction, field by
// field.
// ----------------------------------------------------------------------------
module cda_result_checker import cda_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // first_year, first_month, first_day, second_year, second_month,
  // second_day, day_offset, zero pad
  input  logic [InWidth-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // shifted_year, shifted_month, shifted_day, day_difference, first_greater,
  // dates_equal, first_valid, second_valid, out_of_range, zero pad
  input  logic [OutWidth-1:0] m_axis_tdata,
  output int                  errors_o,
  output int                  pending_o
);

  localparam longint DaysPer400 = 146097;
  localparam longint SatHigh    = 4194303;
  localparam longint SatLow     = -4194304;
  localparam int CommonMonthLen [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  cda_out_t predicted_q[$];
  int       mismatches = 0;

  assign errors_o = mismatches;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_length(longint y, int unsigned m);
    if (m < 1 || m > 12) return 0;
    return CommonMonthLen[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  // day count from 0000-01-01 to the first of January of year y
  function automatic longint days_to_year(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint day_number(longint y, int unsigned m, longint d);
    longint n;
    n = days_to_year(y);
    for (int unsigned k = 1; k < m && k <= 12; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  function automatic bit legal_date(longint y, int unsigned m, longint d);
    return m >= 1 && m <= 12 && d >= 1 && d <= month_length(y, m);
  endfunction

  function automatic cda_out_t compute_date_result(cda_in_t it);
    cda_out_t    r;
    longint      y1, y2, d1, d2, off, s1, t, yr, rem, diff;
    int unsigned m1, m2, mo;
    r   = '0;
    y1  = it.first_year;
    m1  = it.first_month;
    d1  = it.first_day;
    y2  = it.second_year;
    m2  = it.second_month;
    d2  = it.second_day;
    off = longint'(signed'(it.day_offset));
    r.first_valid  = legal_date(y1, m1, d1);
    r.second_valid = legal_date(y2, m2, d2);
    if (!r.first_valid) return r;

    s1 = day_number(y1, m1, d1);
    t  = s1 + off;
    if (t < 0) begin
      r.shifted_year  = 14'd0;
      r.shifted_month = 4'd1;
      r.shifted_day   = 5'd1;
      r.out_of_range  = 1'b1;
    end else if (t >= days_to_year(longint'(MaxYear) + 1)) begin
      r.shifted_year  = 14'(MaxYear);
      r.shifted_month = 4'd12;
      r.shifted_day   = 5'd31;
      r.out_of_range  = 1'b1;
    end else begin
      // take whole 400-year blocks by division, then walk single years, then months
      yr  = 400 * (t / DaysPer400);
      rem = t % DaysPer400;
      while (rem >= (leap_year(yr) ? 366 : 365)) begin
        rem -= leap_year(yr) ? 366 : 365;
        yr++;
      end
      mo = 1;
      while (mo < 12 && rem >= month_length(yr, mo)) begin
        rem -= month_length(yr, mo);
        mo++;
      end
      r.shifted_year  = 14'(yr);
      r.shifted_month = 4'(mo);
      r.shifted_day   = 5'(rem + 1);
    end

    if (r.second_valid) begin
      diff = s1 - day_number(y2, m2, d2);
      if (diff > SatHigh) diff = SatHigh;
      if (diff < SatLow) diff = SatLow;
      r.day_difference = 23'(diff);
    end
    // raw field compare, even when the second date is not legal
    r.first_greater = (y1 > y2) || (y1 == y2 && m1 > m2) ||
                      (y1 == y2 && m1 == m2 && d1 > d2);
    r.dates_equal   = (y1 == y2) && (m1 == m2) && (d1 == d2);
    return r;
  endfunction

  task automatic check_field(string fname, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    cda_out_t want, got;
    if (rst_ni) begin
      // retire first: a returned item always belongs to an earlier input
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with no input pending, got %h", $time, got);
        end else begin
          want = predicted_q.pop_front();
          check_field("shifted_year", want.shifted_year, got.shifted_year);
          check_field("shifted_month", want.shifted_month, got.shifted_month);
          check_field("shifted_day", want.shifted_day, got.shifted_day);
          check_field("day_difference", longint'(signed'(want.day_difference)),
                      longint'(signed'(got.day_difference)));
          check_field("first_greater", want.first_greater, got.first_greater);
          check_field("dates_equal", want.dates_equal, got.dates_equal);
          check_field("first_valid", want.first_valid, got.first_valid);
          check_field("second_valid", want.second_valid, got.second_valid);
          check_field("out_of_range", want.out_of_range, got.out_of_range);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_q.push_back(compute_date_result(s_axis_tdata));
    end
    pending_o <= predicted_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic testbench
// Drives directed and random date pairs with offsets into the core under
// several sender and receiver idle patterns, including one long receiver
// hold-off, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_top import cda_pkg::*; ();

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutWidth-1:0] m_axis_tdata;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_off_req  = 1'b0;

  always #6 clk_i = ~clk_i;

  calendar_date_arithmetic_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cda_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  function automatic cda_in_t date_pair(int y1, int m1, int d1, int y2, int m2, int d2,
                                        int off);
    cda_in_t p;
    p              = '0;
    p.first_year   = 14'(y1);
    p.first_month  = 4'(m1);
    p.first_day    = 5'(d1);
    p.second_year  = 14'(y2);
    p.second_month = 4'(m2);
    p.second_day   = 5'(d2);
    p.day_offset   = 21'(off);
    return p;
  endfunction

  function automatic int pick_year();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) return $urandom_range(9999);
    if (sel < 90) return $urandom_range(16383);
    if (sel < 95) return $urandom_range(3);
    return 9996 + $urandom_range(3);
  endfunction

  function automatic int pick_month();
    if ($urandom_range(99) < 90) return $urandom_range(12, 1);
    return $urandom_range(15);
  endfunction

  function automatic int pick_day();
    if ($urandom_range(99) < 75) return $urandom_range(28, 1);
    return $urandom_range(31);
  endfunction

  function automatic cda_in_t random_date_pair();
    cda_in_t     p;
    int unsigned sel;
    p             = '0;
    p.first_year  = 14'(pick_year());
    p.first_month = 4'(pick_month());
    p.first_day   = 5'(pick_day());
    if ($urandom_range(99) < 25) begin
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
      p.second_day   = p.first_day;
    end else begin
      p.second_year  = 14'(pick_year());
      p.second_month = 4'(pick_month());
      p.second_day   = 5'(pick_day());
    end
    sel = $urandom_range(99);
    if (sel < 40)
      p.day_offset = 21'(int'($urandom_range(800)) - 400);
    else if (sel < 70)
      p.day_offset = 21'(int'($urandom_range(80000)) - 40000);
    else
      p.day_offset = 21'($urandom);
    return p;
  endfunction

  task automatic offer_item(cda_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin : receiver
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        // hold off long enough for the core to fill and stall its input
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(date_pair(2000, 2, 29, 2000, 2, 29, 0));
    offer_item(date_pair(1900, 2, 29, 1900, 3, 1, 5));         // not leap: century
    offer_item(date_pair(2024, 2, 28, 2023, 12, 31, 1));
    offer_item(date_pair(1999, 12, 31, 2000, 1, 1, 1));
    offer_item(date_pair(0, 1, 1, 0, 1, 2, -1));               // clamp below year 0
    offer_item(date_pair(9999, 12, 31, 9999, 12, 30, 1));      // clamp above top year
    offer_item(date_pair(0, 1, 1, 9999, 12, 31, 1048575));
    offer_item(date_pair(9999, 12, 31, 0, 1, 1, -1048576));
    offer_item(date_pair(2010, 0, 10, 2010, 1, 10, 3));
    offer_item(date_pair(2010, 13, 10, 2010, 15, 10, 3));
    offer_item(date_pair(2010, 5, 0, 2010, 5, 1, 3));
    offer_item(date_pair(2010, 4, 31, 2010, 4, 30, 3));
    offer_item(date_pair(2010, 6, 15, 2010, 0, 15, 10));       // second month illegal
    offer_item(date_pair(2010, 6, 15, 2011, 11, 31, -10));     // second day illegal
    offer_item(date_pair(16383, 12, 31, 0, 1, 1, 0));          // clamp, difference saturates
    offer_item(date_pair(10000, 1, 1, 9999, 12, 31, -1));
    offer_item(date_pair(0, 1, 1, 16383, 12, 31, 0));
    offer_item(date_pair(2400, 2, 29, 2100, 2, 28, 365));
    offer_item(date_pair(2021, 2, 29, 2021, 9, 31, 7));        // both illegal
    offer_item(date_pair(16383, 15, 31, 16383, 15, 31, -1));
    offer_item(date_pair(0, 0, 0, 0, 0, 0, 0));
    offer_item(date_pair(2000, 12, 31, 2000, 12, 31, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_off_req  = 1'b1;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 69;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
        end
      endcase
      repeat (30) offer_item(random_date_pair());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
